[rtl/sra_pkg.sv]
// Shared types, constants and codes for the stack region allocator.
`timescale 1ns / 1ps

package sra_pkg;

	// Number of block records on the stack.
	localparam int MAX_BLOCKS = 64;
	// Allocation granule in rows; must be a power of two.
	localparam int ROW_GROUP = 16;

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int TOP_W = $clog2(MAX_BLOCKS + 1);
	localparam int GRP_SHIFT = $clog2(ROW_GROUP);

	localparam int ADDR_W = 32;
	localparam int SIZE_W = 24;
	localparam int REC_W = 31;

	localparam logic [ADDR_W-1:0] TAG_BIT = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] REFUSED_ADDR = 32'hFFFF_FFFF;

	// Request codes.
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_ALLOC = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_FREED = 2'd2;
	localparam logic [1:0] ST_CLEARED = 2'd3;

	typedef struct packed {
		logic [REC_W-1:0] start;
		logic [REC_W-1:0] size;
	} blk_rec_t;

endpackage

[rtl/stack_region_allocator.sv]
// Stack region allocator: block record stack with allocate, free and clear.
//
// Requests arrive on a valid/stall channel (req_valid, req_stall) carrying
// req_type, alloc_size and free_addr; one response word per request leaves
// on rsp_valid/rsp_stall with result_addr and status.
// The block takes one request at a time and holds req_stall high until that
// request's response is in the output register.
// An allocate passes through S_ALLOC and then S_RESP; a clear or a refused
// allocate goes straight to S_RESP. A free reads the top record through the single
// registered memory port, then either pops unused blocks at one per cycle until
// a used block or an empty stack stops it, or walks the records downward through
// S_SRD and S_SCHK for each record. The memory read port sets the free latency.
// A new request may be accepted while a response still waits in the output
// register; when rsp_stall holds, the next response waits in the sequencer
// and req_stall stays high until the output register frees.
// Reset clears the stack pointer, the used bits and the output register at
// once; block records are not cleared and are only read below the stack top,
// so no clearing pass follows reset.
`timescale 1ns / 1ps

module stack_region_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [1:0]                     req_type,
	input  logic [sra_pkg::SIZE_W-1:0]     alloc_size,
	input  logic [sra_pkg::ADDR_W-1:0]     free_addr,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [sra_pkg::ADDR_W-1:0]     result_addr,
	output logic [1:0]                     status
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ALLOC = 4'd1;
	localparam logic [3:0] S_FTOP  = 4'd2;
	localparam logic [3:0] S_POP   = 4'd3;
	localparam logic [3:0] S_SRD   = 4'd4;
	localparam logic [3:0] S_SCHK  = 4'd5;
	localparam logic [3:0] S_RESP  = 4'd6;

	localparam int IDX_W = sra_pkg::IDX_W;
	localparam int TOP_W = sra_pkg::TOP_W;
	localparam int REC_W = sra_pkg::REC_W;

	logic [3:0]                     state_q;
	logic [TOP_W-1:0]               top_q;
	logic [sra_pkg::MAX_BLOCKS-1:0] used_q;
	logic [IDX_W-1:0]               idx_q;
	logic [sra_pkg::SIZE_W-1:0]     size_q;
	logic [REC_W-1:0]               addr_q;
	logic [sra_pkg::ADDR_W-1:0]     res_addr_q;
	logic [1:0]                     res_status_q;
	logic                           rsp_valid_q;
	logic [sra_pkg::ADDR_W-1:0]     result_addr_q;
	logic [1:0]                     status_q;

	sra_pkg::blk_rec_t mem_q [sra_pkg::MAX_BLOCKS];
	sra_pkg::blk_rec_t rd_data_q;
	sra_pkg::blk_rec_t wr_rec;
	logic              mem_we;
	logic [IDX_W-1:0]  rd_addr;

	logic             req_acc;
	logic [TOP_W-1:0] top_m1;
	logic [TOP_W-1:0] top_m2;
	logic [IDX_W-1:0] top_idx;
	logic [IDX_W-1:0] top_m1_idx;
	logic             stack_full;
	logic [sra_pkg::SIZE_W:0] size_rnd;
	logic [REC_W-1:0] groups;
	logic [REC_W-1:0] new_start;
	logic             slot_free;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc = req_valid && !req_stall;

	assign top_m1 = top_q - TOP_W'(1);
	assign top_m2 = top_q - TOP_W'(2);
	assign top_idx = top_q[IDX_W-1:0];
	assign top_m1_idx = top_m1[IDX_W-1:0];
	assign stack_full = (top_q == TOP_W'(sra_pkg::MAX_BLOCKS));

	// Round up to whole row groups.
	assign size_rnd = {1'b0, size_q} + (sra_pkg::SIZE_W + 1)'(sra_pkg::ROW_GROUP - 1);
	assign groups = REC_W'(size_rnd >> sra_pkg::GRP_SHIFT);

	// The new block starts where the one below it ends; the first starts at zero.
	assign new_start = (top_q == '0) ? '0 : (rd_data_q.start + rd_data_q.size);

	assign wr_rec.start = new_start;
	assign wr_rec.size = groups;
	assign mem_we = (state_q == S_ALLOC);

	assign rd_addr = (state_q == S_IDLE) ? top_m1_idx : idx_q;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[top_idx] <= wr_rec;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			top_q <= '0;
			used_q <= '0;
			idx_q <= '0;
			size_q <= '0;
			addr_q <= '0;
			res_addr_q <= '0;
			res_status_q <= sra_pkg::ST_ALLOC;
			rsp_valid_q <= 1'b0;
			result_addr_q <= '0;
			status_q <= sra_pkg::ST_ALLOC;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						size_q <= alloc_size;
						addr_q <= free_addr[REC_W-1:0];
						res_addr_q <= '0;
						case (req_type)
							sra_pkg::REQ_ALLOC: begin
								if (alloc_size == '0 || stack_full) begin
									res_addr_q <= sra_pkg::REFUSED_ADDR;
									res_status_q <= sra_pkg::ST_REFUSED;
									state_q <= S_RESP;
								end else begin
									res_status_q <= sra_pkg::ST_ALLOC;
									state_q <= S_ALLOC;
								end
							end
							sra_pkg::REQ_FREE: begin
								res_status_q <= sra_pkg::ST_FREED;
								state_q <= (top_q == '0) ? S_RESP : S_FTOP;
							end
							default: begin
								used_q <= '0;
								top_q <= '0;
								res_status_q <= sra_pkg::ST_CLEARED;
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_ALLOC: begin
					used_q[top_idx] <= 1'b1;
					top_q <= top_q + TOP_W'(1);
					res_addr_q <= sra_pkg::TAG_BIT | {1'b0, new_start};
					state_q <= S_RESP;
				end
				S_FTOP: begin
					if (rd_data_q.start == addr_q) begin
						used_q[top_m1_idx] <= 1'b0;
						state_q <= S_POP;
					end else if (top_q == TOP_W'(1)) begin
						state_q <= S_RESP;
					end else begin
						idx_q <= top_m2[IDX_W-1:0];
						state_q <= S_SRD;
					end
				end
				S_POP: begin
					if (top_q != '0 && !used_q[top_m1_idx]) begin
						top_q <= top_m1;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SRD: begin
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (rd_data_q.start == addr_q) begin
						used_q[idx_q] <= 1'b0;
						state_q <= S_RESP;
					end else if (idx_q == '0) begin
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_q - IDX_W'(1);
						state_q <= S_SRD;
					end
				end
				S_RESP: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						result_addr_q <= res_addr_q;
						status_q <= res_status_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign result_addr = result_addr_q;
	assign status = status_q;

endmodule

[rtl/sra_checker.sv]
// Port-level checker for the stack region allocator, bound to the top level.
`timescale 1ns / 1ps

module sra_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_stall,
	input logic                       rsp_valid,
	input logic                       rsp_stall,
	input logic [sra_pkg::ADDR_W-1:0] result_addr,
	input logic [1:0]                 status
);

	// A stalled response word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(result_addr) && $stable(status))
		else $error("response word changed while stalled");

	// Only one request is in flight.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in flight");

	a_refused_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == sra_pkg::ST_REFUSED |-> result_addr == sra_pkg::REFUSED_ADDR)
		else $error("refused allocation without all-ones address");

	a_alloc_tag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == sra_pkg::ST_ALLOC |-> result_addr[31])
		else $error("allocated address missing tag bit");

	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == sra_pkg::ST_FREED || status == sra_pkg::ST_CLEARED)
		|-> result_addr == '0)
		else $error("free or clear response with nonzero address");

endmodule

bind stack_region_allocator sra_checker u_sra_checker (.*);

[tb/stack_region_checker.sv]
// Checker for the stack region allocator: predicts each response word and compares it.
`timescale 1ns / 1ps

module stack_region_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_stall,
	input  logic [1:0]                 req_type,
	input  logic [sra_pkg::SIZE_W-1:0] alloc_size,
	input  logic [sra_pkg::ADDR_W-1:0] free_addr,
	input  logic                       rsp_valid,
	input  logic                       rsp_stall,
	input  logic [sra_pkg::ADDR_W-1:0] result_addr,
	input  logic [1:0]                 status,
	output int                         mismatches,
	output int                         waiting
);

	localparam int REC_W = sra_pkg::REC_W;
	localparam int SIZE_W = sra_pkg::SIZE_W;
	localparam int ADDR_W = sra_pkg::ADDR_W;

	logic [REC_W-1:0] rec_base[sra_pkg::MAX_BLOCKS];
	logic [REC_W-1:0] rec_groups[sra_pkg::MAX_BLOCKS];
	bit rec_live[sra_pkg::MAX_BLOCKS];
	int depth = 0;

	logic [ADDR_W-1:0] exp_addr[$];
	logic [1:0] exp_status[$];

	// Applies one accepted request to the block record stack and queues its response.
	task automatic apply_request(input logic [1:0] kind, input logic [SIZE_W-1:0] rows,
		input logic [ADDR_W-1:0] tag_addr);
		logic [REC_W-1:0] groups;
		logic [REC_W-1:0] base;
		logic [REC_W-1:0] key;
		bit hit;
		int k;
		if (kind == sra_pkg::REQ_ALLOC) begin
			if (rows == '0 || depth >= sra_pkg::MAX_BLOCKS) begin
				exp_addr.push_back(sra_pkg::REFUSED_ADDR);
				exp_status.push_back(sra_pkg::ST_REFUSED);
			end else begin
				groups = REC_W'((int'(rows) + sra_pkg::ROW_GROUP - 1) / sra_pkg::ROW_GROUP);
				base = '0;
				if (depth > 0)
					base = rec_base[depth-1] + rec_groups[depth-1];
				rec_base[depth] = base;
				rec_groups[depth] = groups;
				rec_live[depth] = 1'b1;
				depth++;
				exp_addr.push_back(sra_pkg::TAG_BIT | {1'b0, base});
				exp_status.push_back(sra_pkg::ST_ALLOC);
			end
		end else if (kind == sra_pkg::REQ_FREE) begin
			key = tag_addr[REC_W-1:0];
			if (depth > 0) begin
				if (rec_base[depth-1] == key) begin
					// Freeing the top block also pops every unused block beneath it.
					rec_live[depth-1] = 1'b0;
					while (depth > 0 && !rec_live[depth-1])
						depth--;
				end else begin
					hit = 1'b0;
					for (k = depth - 1; k >= 0; k--) begin
						if (!hit && rec_base[k] == key) begin
							rec_live[k] = 1'b0;
							hit = 1'b1;
						end
					end
				end
			end
			exp_addr.push_back('0);
			exp_status.push_back(sra_pkg::ST_FREED);
		end else begin
			// Both the clear code and the spare code empty the stack.
			depth = 0;
			foreach (rec_live[i])
				rec_live[i] = 1'b0;
			exp_addr.push_back('0);
			exp_status.push_back(sra_pkg::ST_CLEARED);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [ADDR_W-1:0] want_addr;
		logic [1:0] want_status;
		if (!arst_n) begin
			depth = 0;
			foreach (rec_live[i])
				rec_live[i] = 1'b0;
			exp_addr.delete();
			exp_status.delete();
			mismatches = 0;
			waiting = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (exp_addr.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word, expected none, actual addr %h status %0d",
						$time, result_addr, status);
				end else begin
					want_addr = exp_addr.pop_front();
					want_status = exp_status.pop_front();
					if (result_addr !== want_addr) begin
						mismatches++;
						$display("%0t: result_addr expected %h actual %h",
							$time, want_addr, result_addr);
					end
					if (status !== want_status) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d",
							$time, want_status, status);
					end
				end
			end
			if (req_valid && !req_stall)
				apply_request(req_type, alloc_size, free_addr);
			waiting = exp_addr.size();
		end
	end

endmodule

[tb/tb_stack_region_allocator.sv]
// Testbench top for the stack region allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_stack_region_allocator;

	localparam int SIZE_W = sra_pkg::SIZE_W;
	localparam int ADDR_W = sra_pkg::ADDR_W;

	// The fourth request code has no name in the package; the block treats it as a clear.
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int QUIET_LIMIT = 6000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 3000;
	localparam int SEGMENTS = 20;
	localparam int SEG_WORDS = 100;

	typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [1:0] req_type;
	logic [SIZE_W-1:0] alloc_size;
	logic [ADDR_W-1:0] free_addr;
	logic rsp_valid;
	logic rsp_stall;
	logic [ADDR_W-1:0] result_addr;
	logic [1:0] status;

	int mismatches;
	int waiting;
	int quiet = 0;
	int rx_cycles = 0;
	bit gaps_on = 1'b1;
	mix_t seg_mode = MIX_BALANCED;
	logic [ADDR_W-1:0] granted[$];

	stack_region_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.alloc_size(alloc_size),
		.free_addr(free_addr),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.result_addr(result_addr),
		.status(status)
	);

	stack_region_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.alloc_size(alloc_size),
		.free_addr(free_addr),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.result_addr(result_addr),
		.status(status),
		.mismatches(mismatches),
		.waiting(waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Granted addresses feed the free requests, so most frees hit a real block.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall && status == sra_pkg::ST_ALLOC) begin
			granted.push_back(result_addr);
			if (granted.size() > 80)
				void'(granted.pop_front());
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic rx_hold(input logic level, input int n);
		rsp_stall = level;
		repeat (n) begin
			@(negedge clk);
			rx_cycles++;
		end
	endtask

	// Receiver: mostly short stalls, stretches with none, and one long hold mid-run.
	initial begin
		int r;
		bit held;
		held = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			if (!held && rx_cycles >= HOLD_AFTER) begin
				held = 1'b1;
				rx_hold(1'b1, HOLD_CYCLES);
			end else if (r < 50) begin
				rx_hold(1'b0, $urandom_range(1, 8));
			end else if (r < 85) begin
				rx_hold(1'b1, $urandom_range(1, 3));
			end else if (r < 95) begin
				rx_hold(1'b0, $urandom_range(20, 60));
			end else begin
				rx_hold(1'b1, $urandom_range(10, 40));
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 70)
			return SIZE_W'($urandom_range(1, 64));
		if (r < 90)
			return SIZE_W'($urandom_range(1, 4096));
		return SIZE_W'($urandom_range(0, 24'hFF_FFFF));
	endfunction

	// Mostly a granted block, often the newest one, with bit 31 set at random.
	function automatic logic [ADDR_W-1:0] pick_free_addr();
		logic [ADDR_W-1:0] addr;
		int idx;
		if (granted.size() == 0 || $urandom_range(0, 99) < 15)
			return $urandom();
		if ($urandom_range(0, 99) < 40)
			idx = granted.size() - 1;
		else
			idx = $urandom_range(0, granted.size() - 1);
		addr = granted[idx];
		granted.delete(idx);
		addr[ADDR_W-1] = 1'($urandom_range(0, 1));
		return addr;
	endfunction

	task automatic send_word(input logic [1:0] kind, input logic [SIZE_W-1:0] rows,
		input logic [ADDR_W-1:0] addr);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid = 1'b1;
		req_type = kind;
		alloc_size = rows;
		free_addr = addr;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_valid = 1'b0;
		while (waiting != 0)
			@(negedge clk);
	endtask

	initial begin
		int r;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = sra_pkg::REQ_ALLOC;
		alloc_size = '0;
		free_addr = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: refusal, empty free, rounding, inner frees and a chained pop.
		send_word(sra_pkg::REQ_ALLOC, 24'd0, 32'h0);
		send_word(sra_pkg::REQ_FREE, 24'hFF_FFFF, 32'h0);
		send_word(sra_pkg::REQ_ALLOC, 24'd1, 32'hFFFF_FFFF);
		send_word(sra_pkg::REQ_ALLOC, 24'd16, 32'h0);
		send_word(sra_pkg::REQ_ALLOC, 24'd17, 32'h0);
		send_word(sra_pkg::REQ_ALLOC, 24'hFF_FFFF, 32'h0);
		send_word(sra_pkg::REQ_FREE, 24'd0, 32'h7FFF_FFF0);
		send_word(sra_pkg::REQ_FREE, 24'd0, 32'h8000_0001);
		send_word(sra_pkg::REQ_FREE, 24'd0, 32'h0000_0002);
		send_word(sra_pkg::REQ_FREE, 24'd0, 32'h8000_0004);
		send_word(sra_pkg::REQ_ALLOC, 24'd32, 32'h0);
		send_word(sra_pkg::REQ_FREE, 24'd0, 32'hFFFF_FFFF);
		send_word(sra_pkg::REQ_CLEAR, 24'hFF_FFFF, 32'hFFFF_FFFF);
		send_word(sra_pkg::REQ_FREE, 24'd0, 32'h8000_0000);
		send_word(sra_pkg::REQ_ALLOC, 24'd5, 32'h0);
		send_word(REQ_SPARE, 24'd0, 32'h0);
		send_word(sra_pkg::REQ_ALLOC, 24'd15, 32'h0);
		send_word(sra_pkg::REQ_FREE, 24'd0, 32'h0000_0000);
		wait_drained();

		for (int s = 0; s < SEGMENTS; s++) begin
			if (s == SEGMENTS / 2)
				wait_drained();
			gaps_on = ($urandom_range(0, 3) != 0);
			if (s % 4 == 1)
				seg_mode = MIX_FILL;
			else
				seg_mode = mix_t'($urandom_range(0, 2));
			for (int n = 0; n < SEG_WORDS; n++) begin
				r = $urandom_range(0, 99);
				if ((seg_mode == MIX_FILL && r < 92) || (seg_mode == MIX_DRAIN && r < 15) ||
					(seg_mode == MIX_BALANCED && r < 50))
					send_word(sra_pkg::REQ_ALLOC, pick_size(), $urandom());
				else if (seg_mode != MIX_BALANCED || r < 92)
					send_word(sra_pkg::REQ_FREE, SIZE_W'($urandom()), pick_free_addr());
				else if (r < 96)
					send_word(sra_pkg::REQ_CLEAR, SIZE_W'($urandom()), $urandom());
				else
					send_word(REQ_SPARE, SIZE_W'($urandom()), $urandom());
			end
		end

		wait_drained();
		repeat (200) @(negedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
